/* src/point_transform_crop_filter_macros.svh */
// assertion helpers for the point crop filter
`ifndef POINT_TRANSFORM_CROP_FILTER_MACROS_SVH
`define POINT_TRANSFORM_CROP_FILTER_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, off while reset is asserted
`define PTCF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ptcf assertion failed");
// clocked check that also holds during reset
`define PTCF_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ptcf reset assertion failed");
`else
`define PTCF_ASSERT(lbl, clk, rst_n, prop)
`define PTCF_ASSERT_RST(lbl, clk, prop)
`endif
`endif

/* src/ptcf_pkg.sv */
package ptcf_pkg;

  // field widths
  localparam int COORD_BITS = 24;
  localparam int COEF_BITS  = 18;
  localparam int OFF_BITS   = 20;
  localparam int LIM_BITS   = 24;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_W     = COEF_BITS + COORD_BITS;
  localparam int ACC_W      = (PROD_W + 3 > LIM_BITS + FRAC_BITS + 1) ?
                              PROD_W + 3 : LIM_BITS + FRAC_BITS + 1;
  localparam int TDATA_W    = ((3 * COORD_BITS + 7) / 8) * 8;

  // configuration port
  localparam int CFG_DATA_W = 60;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ROT_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_Z_LIM   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd7;

  // mode flag bits
  localparam int MODE_FILTER = 0;
  localparam int MODE_BOX    = 1;
  localparam int MODE_BELOW  = 2;
  localparam int MODE_ABOVE  = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COEF_BITS-1:0]  coef_t;
  typedef logic signed [OFF_BITS-1:0]   off_t;
  typedef logic signed [LIM_BITS-1:0]   lim_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [ACC_W-1:0]      acc_t;

  typedef struct packed {
    logic [3*COEF_BITS-1:0] rot_x;
    logic [3*COEF_BITS-1:0] rot_y;
    logic [3*COEF_BITS-1:0] rot_z;
    logic [3*OFF_BITS-1:0]  trans;
    logic [3*OFF_BITS-1:0]  box_min;
    logic [3*OFF_BITS-1:0]  box_max;
    logic [2*LIM_BITS-1:0]  z_lim;
    logic [3:0]             mode;
  } cfg_t;

  // one point plus its sideband as it moves down the pipe
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   not_finite;
    logic   last;
  } point_t;

  // offset or bound in 1/1024 m brought to the 2^-16 product scale
  function automatic acc_t scale_off(off_t v);
    return ACC_W'($signed({v, {FRAC_BITS{1'b0}}}));
  endfunction

  function automatic acc_t scale_lim(lim_t v);
    return ACC_W'($signed({v, {FRAC_BITS{1'b0}}}));
  endfunction

endpackage

/* src/ptcf_cfg.sv */
module ptcf_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                we_i,
  input  logic [ptcf_pkg::CFG_IDX_W-1:0]      idx_i,
  input  logic [ptcf_pkg::CFG_DATA_W-1:0]     data_i,
  output ptcf_pkg::cfg_t                      cfg_o
);
  import ptcf_pkg::*;

  cfg_t cfg_d, cfg_q;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (idx_i)
        REG_ROT_X:   cfg_d.rot_x   = data_i[3*COEF_BITS-1:0];
        REG_ROT_Y:   cfg_d.rot_y   = data_i[3*COEF_BITS-1:0];
        REG_ROT_Z:   cfg_d.rot_z   = data_i[3*COEF_BITS-1:0];
        REG_TRANS:   cfg_d.trans   = data_i[3*OFF_BITS-1:0];
        REG_BOX_MIN: cfg_d.box_min = data_i[3*OFF_BITS-1:0];
        REG_BOX_MAX: cfg_d.box_max = data_i[3*OFF_BITS-1:0];
        REG_Z_LIM:   cfg_d.z_lim   = data_i[2*LIM_BITS-1:0];
        REG_MODE:    cfg_d.mode    = data_i[3:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  // identity rotation, zero offset, default self box and z limits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot_x   <= 54'd65536;
      cfg_q.rot_y   <= 54'd17179869184;
      cfg_q.rot_z   <= 54'd4503599627370496;
      cfg_q.trans   <= 60'd0;
      cfg_q.box_min <= 60'd1152641128712896051;
      cfg_q.box_max <= 60'd900500453065165;
      cfg_q.z_lim   <= 48'd34359738419;
      cfg_q.mode    <= 4'd3;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/ptcf_xform.sv */
module ptcf_xform (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptcf_pkg::cfg_t    cfg_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  ptcf_pkg::point_t  point_i,
  output logic              valid_o,
  input  logic              ready_i,
  output ptcf_pkg::point_t  point_o,
  output ptcf_pkg::acc_t    tx_o,
  output ptcf_pkg::acc_t    ty_o,
  output ptcf_pkg::acc_t    tz_o
);
  import ptcf_pkg::*;

  logic [3*COEF_BITS-1:0] rows [3];
  coord_t                 coords [3];
  prod_t                  prod_d [3][3];
  prod_t                  prod_q [3][3];
  acc_t                   sum_d [3];
  acc_t                   sum_q [3];
  point_t                 pa_q, pb_q;
  logic                   va_q, vb_q;
  logic                   ready_a, ready_b;

  assign rows[0]   = cfg_i.rot_x;
  assign rows[1]   = cfg_i.rot_y;
  assign rows[2]   = cfg_i.rot_z;
  assign coords[0] = point_i.x;
  assign coords[1] = point_i.y;
  assign coords[2] = point_i.z;

  // stage ready chain: a stage moves when empty or when the next one moves
  assign ready_b = !vb_q || ready_i;
  assign ready_a = !va_q || ready_b;
  assign ready_o = ready_a;

  // stage a: nine coefficient times coordinate products
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      coef_t coef;
      assign coef        = rows[r][c*COEF_BITS +: COEF_BITS];
      assign prod_d[r][c] = coef * coords[c];
    end
    // stage b: row sum plus scaled offset
    assign sum_d[r] = ACC_W'(prod_q[r][0]) + ACC_W'(prod_q[r][1]) + ACC_W'(prod_q[r][2])
                    + scale_off(cfg_i.trans[r*OFF_BITS +: OFF_BITS]);
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (ready_a) va_q <= valid_i;
      if (ready_b) vb_q <= va_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ready_a && valid_i) begin
      pa_q <= point_i;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= prod_d[r][c];
        end
      end
    end
    if (ready_b && va_q) begin
      pb_q <= pa_q;
      for (int r = 0; r < 3; r++) begin
        sum_q[r] <= sum_d[r];
      end
    end
  end

  assign valid_o = vb_q;
  assign point_o = pb_q;
  assign tx_o    = sum_q[0];
  assign ty_o    = sum_q[1];
  assign tz_o    = sum_q[2];

endmodule

/* src/ptcf_check.sv */
module ptcf_check (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptcf_pkg::cfg_t    cfg_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  ptcf_pkg::point_t  point_i,
  input  ptcf_pkg::acc_t    tx_i,
  input  ptcf_pkg::acc_t    ty_i,
  input  ptcf_pkg::acc_t    tz_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic              keep_o,
  output ptcf_pkg::point_t  point_o
);
  import ptcf_pkg::*;

  acc_t   t [3];
  logic   in_axis [3];
  logic   in_box, below, above, remove, keep_d;
  logic   keep_q, vc_q;
  point_t pc_q;
  lim_t   z_lo, z_hi;

  assign t[0] = tx_i;
  assign t[1] = ty_i;
  assign t[2] = tz_i;
  assign z_lo = cfg_i.z_lim[LIM_BITS-1:0];
  assign z_hi = cfg_i.z_lim[2*LIM_BITS-1:LIM_BITS];

  // inclusive box test per axis
  for (genvar a = 0; a < 3; a++) begin : g_axis
    acc_t lo, hi;
    assign lo         = scale_off(cfg_i.box_min[a*OFF_BITS +: OFF_BITS]);
    assign hi         = scale_off(cfg_i.box_max[a*OFF_BITS +: OFF_BITS]);
    assign in_axis[a] = (t[a] >= lo) && (t[a] <= hi);
  end

  // removal decision
  always_comb begin
    in_box = in_axis[0] && in_axis[1] && in_axis[2];
    below  = tz_i < scale_lim(z_lo);
    above  = tz_i > scale_lim(z_hi);
    remove = point_i.not_finite
           || (cfg_i.mode[MODE_BOX]   && in_box)
           || (cfg_i.mode[MODE_BELOW] && below)
           || (cfg_i.mode[MODE_ABOVE] && above);
    keep_d = !cfg_i.mode[MODE_FILTER] || !remove;
  end

  // output register
  assign ready_o = !vc_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (ready_o) begin
      vc_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      keep_q <= keep_d;
      pc_q   <= point_i;
    end
  end

  assign valid_o = vc_q;
  assign keep_o  = keep_q;
  assign point_o = pc_q;

endmodule

/* src/point_transform_crop_filter.sv */
// Point crop filter: takes one lidar point per clock (x, y, z signed, 1/1024 m,
// with a non-finite flag in tuser and the last-of-cloud mark in tlast), rotates
// and translates it with the configured transform at full precision, and
// returns the original coordinates with a keep flag in tuser. The pipeline has
// three register stages (products, row sums, box and z tests into the output
// register), and a word passes through them in that order; a new word is
// accepted every cycle while the output is not stalled, and the ready chain
// through the stages lets a stalled output fill the empty stages before the
// input side is held.
// The user must write configuration through cfg_we_i / cfg_idx_i / cfg_data_i
// only while no words are in flight; the block itself does not enforce this.
`include "point_transform_crop_filter_macros.svh"

module point_transform_crop_filter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [ptcf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ptcf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // input points
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [ptcf_pkg::TDATA_W-1:0]        s_axis_tdata,  // x_coord, y_coord, z_coord
  input  logic                                s_axis_tuser,  // not_finite
  input  logic                                s_axis_tlast,
  // filtered points
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [ptcf_pkg::TDATA_W-1:0]        m_axis_tdata,  // out_x, out_y, out_z
  output logic                                m_axis_tuser,  // keep
  output logic                                m_axis_tlast
);
  import ptcf_pkg::*;

  cfg_t   cfg;
  point_t pt_in, pt_xf, pt_out;
  acc_t   tx, ty, tz;
  logic   xf_valid, xf_ready;

  ptcf_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  // unpack the input word
  assign pt_in.x          = s_axis_tdata[COORD_BITS-1:0];
  assign pt_in.y          = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
  assign pt_in.z          = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
  assign pt_in.not_finite = s_axis_tuser;
  assign pt_in.last       = s_axis_tlast;

  ptcf_xform u_xform (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .point_i (pt_in),
    .valid_o (xf_valid),
    .ready_i (xf_ready),
    .point_o (pt_xf),
    .tx_o    (tx),
    .ty_o    (ty),
    .tz_o    (tz)
  );

  ptcf_check u_check (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (xf_valid),
    .ready_o (xf_ready),
    .point_i (pt_xf),
    .tx_i    (tx),
    .ty_i    (ty),
    .tz_i    (tz),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .keep_o  (m_axis_tuser),
    .point_o (pt_out)
  );

  // pack the output word, zero filled to whole bytes
  assign m_axis_tdata = TDATA_W'({pt_out.z, pt_out.y, pt_out.x});
  assign m_axis_tlast = pt_out.last;

  // with filtering off every point is kept
  `PTCF_ASSERT(a_keep_when_off, clk_i, rst_ni, m_axis_tvalid && !cfg.mode[MODE_FILTER] |-> m_axis_tuser)
  // input is held only when every stage is full and the output is stalled
  `PTCF_ASSERT(a_hold_only_full, clk_i, rst_ni, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
  // nothing is offered in the cycle after a reset edge
  `PTCF_ASSERT_RST(a_reset_empty, clk_i, !rst_ni |=> !m_axis_tvalid)

endmodule
